// ===== hw/rtl/suia_pkg.sv =====
// Shared types, command codes and the divider step for the signed/unsigned ALU.
`default_nettype none

package suia_pkg;

   localparam int DataW    = 64;
   localparam int HalfW    = DataW / 2;
   localparam int CmdW     = 5;
   localparam int ShiftW   = 6;              // shift amount is taken modulo 64
   localparam int DivSteps = DataW;          // one quotient bit per stage

   typedef enum logic [CmdW-1:0] {
      CMD_MUL  = 5'd0,
      CMD_DIV  = 5'd1,
      CMD_REM  = 5'd2,
      CMD_ADD  = 5'd3,
      CMD_SUB  = 5'd4,
      CMD_SHL  = 5'd5,
      CMD_SHR  = 5'd6,
      CMD_AND  = 5'd7,
      CMD_XOR  = 5'd8,
      CMD_OR   = 5'd9,
      CMD_LT   = 5'd10,
      CMD_GT   = 5'd11,
      CMD_LE   = 5'd12,
      CMD_GE   = 5'd13,
      CMD_EQ   = 5'd14,
      CMD_NE   = 5'd15,
      CMD_LAND = 5'd16,
      CMD_LOR  = 5'd17
   } cmd_type;

   typedef struct packed {
      logic [CmdW-1:0]    command;
      logic signed [63:0] left_value;
      logic               left_is_unsigned;
      logic signed [63:0] right_value;
      logic               right_is_unsigned;
   } req_type;

   typedef struct packed {
      logic signed [63:0] result_value;
      logic               result_is_unsigned;
      logic               divide_by_zero;
   } rsp_type;

   // Everything that rides alongside the divider.
   typedef struct packed {
      logic [CmdW-1:0]  cmd;
      logic             tag;
      logic             dz;
      logic             na;      // dividend was negated
      logic             nb;      // divisor was negated
      logic [DataW-1:0] early;   // result of every non-divide command
   } div_side_type;

   typedef struct packed {
      logic [DataW-1:0] rem;
      logic [DataW-1:0] quo;     // dividend shifts out, quotient shifts in
      logic [DataW-1:0] dvs;
      div_side_type     side;
   } div_stage_type;

   // One restoring division step.
   function automatic div_stage_type div_step(input div_stage_type s);
      logic [DataW:0]   sh;
      logic [DataW+1:0] diff;
      div_stage_type    o;
      sh    = {s.rem, s.quo[DataW-1]};
      diff  = {1'b0, sh} - {2'b00, s.dvs};
      o     = s;
      o.quo = {s.quo[DataW-2:0], ~diff[DataW+1]};
      o.rem = diff[DataW+1] ? sh[DataW-1:0] : diff[DataW-1:0];
      return o;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/suia_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module suia_div_pipe
   import suia_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          enable,
   input  wire logic          in_valid,
   input  wire div_stage_type in_stage,
   output logic               out_valid,
   output div_stage_type      out_stage
);

   div_stage_type       pipe_ff [DivSteps];
   div_stage_type       step_in [DivSteps];
   logic [DivSteps-1:0] valid_ff;

   always_comb begin
      step_in[0] = div_step(in_stage);
      for (int k = 1; k < DivSteps; k++) begin
         step_in[k] = div_step(pipe_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[DivSteps-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < DivSteps; k++) begin
            pipe_ff[k] <= step_in[k];
         end
      end
   end

   assign out_valid = valid_ff[DivSteps-1];
   assign out_stage = pipe_ff[DivSteps-1];

endmodule

`default_nettype wire

// ===== hw/rtl/signed_unsigned_integer_alu.sv =====
// Top level: 64-bit integer ALU with per-operand signedness tags.
// Every command takes the same path from req transfer to rsp valid: operand register,
//   multiply and sum registers, the 64-stage divider, then the output register.
// Throughput: one transfer per cycle; the whole pipeline advances when the output
//   register is empty or being taken, and holds otherwise.
// Reset: synchronous, active high; clears all valid bits, payload is not reset.
`default_nettype none

module signed_unsigned_integer_alu
   import suia_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   // Global advance: the pipeline moves whenever the output slot frees up.
   logic enable;

   // Stage 1: operand register.
   logic    s1_valid_ff;
   req_type s1_ff;

   // Stage 2: simple ops done, magnitudes and partial products.
   logic             s2_valid_ff;
   div_side_type     s2_side_ff, s2_side_in;
   logic [DataW-1:0] s2_ma_ff, s2_ma_in;
   logic [DataW-1:0] s2_mb_ff, s2_mb_in;
   logic [DataW-1:0] pp_ll_ff;
   logic [HalfW-1:0] pp_lh_ff, pp_hl_ff;
   logic [DataW-1:0] prod_ll, prod_lh, prod_hl;

   // Stage 3: multiply sum, divider entry.
   logic          s3_valid_ff;
   div_stage_type s3_ff, s3_in;

   // Divider output.
   logic          div_valid;
   div_stage_type div_out;

   // Output register.
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   assign enable    = !rsp_valid_ff || rsp_ready;
   assign req_ready = enable;

   // ---------------- stage 1 ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_ff <= req_payload;
      end
   end

   // ---------------- stage 2 ----------------
   logic [DataW-1:0]  a, b;
   logic              au, bu, uns, lt, gt, eq;
   logic [ShiftW-1:0] sh;

   always_comb begin
      a   = s1_ff.left_value;
      b   = s1_ff.right_value;
      au  = s1_ff.left_is_unsigned;
      bu  = s1_ff.right_is_unsigned;
      uns = au || bu;
      sh  = b[ShiftW-1:0];
      eq  = (a == b);
      // signed compare by flipping the sign bits
      lt  = uns ? (a < b) : ({~a[DataW-1], a[DataW-2:0]} < {~b[DataW-1], b[DataW-2:0]});
      gt  = !lt && !eq;

      s2_side_in.cmd = s1_ff.command;
      s2_side_in.na  = !uns && a[DataW-1];
      s2_side_in.nb  = !uns && b[DataW-1];
      s2_side_in.dz  = 1'b0;
      s2_side_in.tag = 1'b0;
      s2_ma_in = s2_side_in.na ? (~a + 1'b1) : a;
      s2_mb_in = s2_side_in.nb ? (~b + 1'b1) : b;

      s2_side_in.early = '0;
      case (cmd_type'(s1_ff.command))
         CMD_MUL: begin
            s2_side_in.tag = uns;
         end
         CMD_DIV, CMD_REM: begin
            s2_side_in.tag = uns;
            s2_side_in.dz  = (b == '0);
         end
         CMD_ADD: begin
            s2_side_in.tag   = uns;
            s2_side_in.early = a + b;
         end
         CMD_SUB: begin
            s2_side_in.tag   = uns;
            s2_side_in.early = a - b;
         end
         CMD_SHL: begin
            s2_side_in.tag   = au;
            s2_side_in.early = a << sh;
         end
         CMD_SHR: begin
            s2_side_in.tag   = au;
            s2_side_in.early = au ? (a >> sh) : $unsigned($signed(a) >>> sh);
         end
         CMD_AND: begin
            s2_side_in.tag   = uns;
            s2_side_in.early = a & b;
         end
         CMD_XOR: begin
            s2_side_in.tag   = uns;
            s2_side_in.early = a ^ b;
         end
         CMD_OR: begin
            s2_side_in.tag   = uns;
            s2_side_in.early = a | b;
         end
         CMD_LT:   s2_side_in.early = {{(DataW-1){1'b0}}, lt};
         CMD_GT:   s2_side_in.early = {{(DataW-1){1'b0}}, gt};
         CMD_LE:   s2_side_in.early = {{(DataW-1){1'b0}}, !gt};
         CMD_GE:   s2_side_in.early = {{(DataW-1){1'b0}}, !lt};
         CMD_EQ:   s2_side_in.early = {{(DataW-1){1'b0}}, eq};
         CMD_NE:   s2_side_in.early = {{(DataW-1){1'b0}}, !eq};
         CMD_LAND: s2_side_in.early = {{(DataW-1){1'b0}}, (a != '0) && (b != '0)};
         CMD_LOR:  s2_side_in.early = {{(DataW-1){1'b0}}, (a != '0) || (b != '0)};
         default:  s2_side_in.early = '0;
      endcase
   end

   // low 64 bits of the product from three 32x32 partial products
   assign prod_ll = a[HalfW-1:0] * b[HalfW-1:0];
   assign prod_lh = a[HalfW-1:0] * b[DataW-1:HalfW];
   assign prod_hl = a[DataW-1:HalfW] * b[HalfW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (enable) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s2_side_ff <= s2_side_in;
         s2_ma_ff   <= s2_ma_in;
         s2_mb_ff   <= s2_mb_in;
         pp_ll_ff   <= prod_ll;
         pp_lh_ff   <= prod_lh[HalfW-1:0];
         pp_hl_ff   <= prod_hl[HalfW-1:0];
      end
   end

   // ---------------- stage 3 ----------------
   logic [HalfW-1:0] cross_sum;

   always_comb begin
      cross_sum = pp_lh_ff + pp_hl_ff;
      s3_in.rem  = '0;
      s3_in.quo  = s2_ma_ff;
      s3_in.dvs  = s2_mb_ff;
      s3_in.side = s2_side_ff;
      if (cmd_type'(s2_side_ff.cmd) == CMD_MUL) begin
         s3_in.side.early = pp_ll_ff + {cross_sum, {HalfW{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (enable) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s3_ff <= s3_in;
      end
   end

   // ---------------- divider ----------------
   suia_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (s3_valid_ff),
      .in_stage  (s3_ff),
      .out_valid (div_valid),
      .out_stage (div_out)
   );

   // ---------------- output register ----------------
   always_comb begin
      rsp_in.result_is_unsigned = div_out.side.tag;
      rsp_in.divide_by_zero     = div_out.side.dz;
      case (cmd_type'(div_out.side.cmd))
         CMD_DIV: begin
            if (div_out.side.dz) begin
               rsp_in.result_value = '0;
            end else begin
               rsp_in.result_value = (div_out.side.na != div_out.side.nb)
                                     ? (~div_out.quo + 1'b1) : div_out.quo;
            end
         end
         CMD_REM: begin
            if (div_out.side.dz) begin
               rsp_in.result_value = '0;
            end else begin
               rsp_in.result_value = div_out.side.na ? (~div_out.rem + 1'b1) : div_out.rem;
            end
         end
         default: rsp_in.result_value = div_out.side.early;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // ---------------- assertions ----------------
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.divide_by_zero |-> rsp_ff.result_value == '0)
      else $error("divide by zero result not zero");

   a_s1_advance: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && enable |=> s2_valid_ff)
      else $error("item lost between stage 1 and stage 2");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !enable && s3_valid_ff |=> s3_valid_ff && $stable(s3_ff))
      else $error("stage 3 changed during stall");

endmodule

`default_nettype wire
